// ===== rtl/cbdrp_pkg.sv =====
// Shared definitions for the console bus decoder with controller ports.
// Holds operation and target codes, decode addresses, the button mapping
// and the command and status structs between the controller and datapath.
package cbdrp_pkg;

  localparam int RAM_DEPTH_DEF = 2048;

  localparam logic [2:0] OP_CPU_RD  = 3'd0;
  localparam logic [2:0] OP_CPU_WR  = 3'd1;
  localparam logic [2:0] OP_PPU_RD  = 3'd2;
  localparam logic [2:0] OP_PPU_WR  = 3'd3;
  localparam logic [2:0] OP_BUTTONS = 3'd4;

  localparam logic [2:0] TGT_INTERNAL = 3'd0;
  localparam logic [2:0] TGT_PPU_REGS = 3'd1;
  localparam logic [2:0] TGT_APU      = 3'd2;
  localparam logic [2:0] TGT_CART_PRG = 3'd3;
  localparam logic [2:0] TGT_DMA      = 3'd4;
  localparam logic [2:0] TGT_PPU_MEM  = 3'd5;
  localparam logic [2:0] TGT_CART_CHR = 3'd6;

  localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
  localparam logic [15:0] ADDR_APU_BASE  = 16'h4000;
  localparam logic [15:0] ADDR_CART_BASE = 16'h4020;
  localparam logic [15:0] ADDR_DMA       = 16'h4014;
  localparam logic [15:0] ADDR_PAD0      = 16'h4016;
  localparam logic [15:0] ADDR_PAD1      = 16'h4017;
  localparam logic [15:0] PPU_REG_MASK   = 16'h0007;
  localparam logic [15:0] PPU_ADDR_MASK  = 16'h3FFF;

  localparam logic [7:0] PAD_REFILL   = 8'h80;
  localparam logic [7:0] PAD_OPEN_BUS = 8'h40;

  typedef struct packed {
    logic load;
    logic exec_en;
    logic clear_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  // Host buttons to latch order A, B, Select, Start, Up, Down, Left, Right.
  function automatic logic [7:0] map_buttons(input logic [11:0] v);
    return {v[11], v[10], v[9], v[8], v[6], v[7], v[1], v[0]};
  endfunction

endpackage

// ===== rtl/cbdrp_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
module cbdrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/cbdrp_dpath.sv =====
// Datapath: input registers, address decode, controller port shifters,
// work RAM with its clearing counter, and the result registers.
// Depends on cbdrp_pkg and cbdrp_ram.
module cbdrp_dpath import cbdrp_pkg::*; #(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic        in_pad_index,
  input  logic [11:0] in_virtual_buttons,
  output logic [7:0]  out_read_byte,
  output logic [2:0]  out_target,
  output logic [15:0] out_target_address,
  output logic [7:0]  out_target_data,
  output logic        out_is_write
);

  localparam int AW = $clog2(RAM_DEPTH);
  localparam logic [16:0] DEP17 = 17'(RAM_DEPTH);

  logic [2:0]  op_r;
  logic [15:0] addr_r;
  logic [7:0]  wdat_r;
  logic        pad_r;
  logic [11:0] vb_r;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          strobe_r, strobe_nxt;
  logic [1:0][7:0] latch_r, latch_nxt;
  logic [1:0][7:0] shift_r, shift_nxt;

  logic [2:0]  tg_r, tg_nxt;
  logic [15:0] ta_r, ta_nxt;
  logic [7:0]  td_r, td_nxt;
  logic        wr_r, wr_nxt;
  logic [7:0]  rb_r, rb_nxt;
  logic        use_ram_r, use_ram_nxt;

  logic [16:0]   rem;
  logic [AW-1:0] ram_idx;
  logic          ram_hit;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          pad_sel;
  logic [15:0]   ppu_addr;
  logic [7:0]    btn_map;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      addr_r <= in_bus_address;
      wdat_r <= in_write_byte;
      pad_r  <= in_pad_index;
      vb_r   <= in_virtual_buttons;
    end
  end

  // Mirror reduction of a 13-bit address, at most fifteen depths deep.
  always_comb begin
    rem = 17'(addr_r[12:0]);
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (DEP17 << k)) begin
        rem = rem - (DEP17 << k);
      end
    end
    ram_idx = rem[AW-1:0];
  end

  always_comb begin
    tg_nxt      = TGT_INTERNAL;
    ta_nxt      = '0;
    td_nxt      = '0;
    wr_nxt      = 1'b0;
    rb_nxt      = '0;
    use_ram_nxt = 1'b0;
    ram_hit     = 1'b0;
    strobe_nxt  = strobe_r;
    latch_nxt   = latch_r;
    shift_nxt   = shift_r;
    pad_sel     = (addr_r == ADDR_PAD1);
    ppu_addr    = addr_r & PPU_ADDR_MASK;
    btn_map     = map_buttons(vb_r);
    unique case (op_r)
      OP_CPU_RD, OP_CPU_WR: begin
        priority if (addr_r < ADDR_PPU_BASE) begin
          tg_nxt = TGT_INTERNAL;
          ta_nxt = 16'(ram_idx);
          if (op_r == OP_CPU_WR) begin
            ram_hit = 1'b1;
          end else begin
            use_ram_nxt = 1'b1;
          end
        end else if (addr_r < ADDR_APU_BASE) begin
          tg_nxt = TGT_PPU_REGS;
          ta_nxt = addr_r & PPU_REG_MASK;
        end else if (addr_r < ADDR_CART_BASE) begin
          priority if (op_r == OP_CPU_WR && addr_r == ADDR_DMA) begin
            tg_nxt = TGT_DMA;
            ta_nxt = {wdat_r, 8'h00};
          end else if (op_r == OP_CPU_WR && addr_r == ADDR_PAD0) begin
            tg_nxt     = TGT_INTERNAL;
            ta_nxt     = addr_r;
            strobe_nxt = wdat_r[0];
            if (wdat_r[0]) begin
              shift_nxt = latch_r;
            end
          end else if (op_r == OP_CPU_RD && (addr_r == ADDR_PAD0 || addr_r == ADDR_PAD1)) begin
            tg_nxt = TGT_INTERNAL;
            ta_nxt = addr_r;
            if (strobe_r) begin
              shift_nxt[pad_sel] = latch_r[pad_sel];
              rb_nxt = PAD_OPEN_BUS | {7'b0, latch_r[pad_sel][0]};
            end else begin
              shift_nxt[pad_sel] = PAD_REFILL | {1'b0, shift_r[pad_sel][7:1]};
              rb_nxt = PAD_OPEN_BUS | {7'b0, shift_r[pad_sel][0]};
            end
          end else begin
            tg_nxt = TGT_APU;
            ta_nxt = addr_r;
          end
        end else begin
          tg_nxt = TGT_CART_PRG;
          ta_nxt = addr_r;
        end
        if (op_r == OP_CPU_WR) begin
          wr_nxt = 1'b1;
          td_nxt = wdat_r;
        end
      end
      OP_PPU_RD, OP_PPU_WR: begin
        tg_nxt = (ppu_addr < ADDR_PPU_BASE) ? TGT_CART_CHR : TGT_PPU_MEM;
        ta_nxt = ppu_addr;
        if (op_r == OP_PPU_WR) begin
          wr_nxt = 1'b1;
          td_nxt = wdat_r;
        end
      end
      OP_BUTTONS: begin
        latch_nxt[pad_r] = btn_map;
        if (strobe_r) begin
          shift_nxt[pad_r] = btn_map;
        end
      end
      default: begin
      end
    endcase
  end

  assign clr_cnt_nxt = clr_cnt_r + AW'(1);
  assign status.clear_last = (clr_cnt_r == AW'(RAM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      strobe_r  <= 1'b0;
      latch_r   <= '0;
      shift_r   <= '0;
    end else begin
      if (cmd.clear_en) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      if (cmd.exec_en) begin
        strobe_r <= strobe_nxt;
        latch_r  <= latch_nxt;
        shift_r  <= shift_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_en) begin
      tg_r      <= tg_nxt;
      ta_r      <= ta_nxt;
      td_r      <= td_nxt;
      wr_r      <= wr_nxt;
      rb_r      <= rb_nxt;
      use_ram_r <= use_ram_nxt;
    end
  end

  assign ram_we    = cmd.clear_en | (cmd.exec_en & ram_hit);
  assign ram_addr  = cmd.clear_en ? clr_cnt_r : ram_idx;
  assign ram_wdata = cmd.clear_en ? 8'h00 : wdat_r;

  cbdrp_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_work_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign out_read_byte      = use_ram_r ? ram_rdata : rb_r;
  assign out_target         = tg_r;
  assign out_target_address = ta_r;
  assign out_target_data    = td_r;
  assign out_is_write       = wr_r;

endmodule

// ===== rtl/cbdrp_ctrl.sv =====
// Controller: sequences the RAM clearing pass after reset, then issues
// one execute step per accepted transfer and raises the result strobe.
// Depends on cbdrp_pkg.
module cbdrp_ctrl import cbdrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        valid_r;

  assign busy         = (state_r == ST_CLEAR);
  assign cmd.load     = start & ~busy;
  assign cmd.exec_en  = (state_r == ST_EXEC);
  assign cmd.clear_en = (state_r == ST_CLEAR);
  assign out_valid    = valid_r;

  always_comb begin
    unique case (state_r)
      ST_CLEAR: state_nxt = status.clear_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:  state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC:  state_nxt = start ? ST_EXEC : ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.exec_en;
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe during the clearing pass");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transfer produced no result two cycles later");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an execute step");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("clearing pass left for an execute step");

endmodule

// ===== rtl/console_bus_decode_ram_pads_unit.sv =====
// Top level of the console bus decoder with RAM and controller ports.
// Depends on cbdrp_pkg, cbdrp_ctrl and cbdrp_dpath.
//
// After reset the block runs a clearing pass that zeroes the work RAM, one
// entry per cycle, and busy stays high until the last entry is written. After
// that busy stays low and one transfer can be started every cycle. Each
// transfer gives exactly one result, shown for one cycle with out_valid;
// it passes the input registers, then the result registers or work RAM read.
// The receiver cannot stall results, so out_valid must be sampled every cycle.
module console_bus_decode_ram_pads_unit import cbdrp_pkg::*; #(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic        in_pad_index,
  input  logic [11:0] in_virtual_buttons,
  output logic        out_valid,
  output logic [7:0]  out_read_byte,
  output logic [2:0]  out_target,
  output logic [15:0] out_target_address,
  output logic [7:0]  out_target_data,
  output logic        out_is_write
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cbdrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .status   (status),
    .cmd      (cmd)
  );

  cbdrp_dpath #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (in_operation),
    .in_bus_address    (in_bus_address),
    .in_write_byte     (in_write_byte),
    .in_pad_index      (in_pad_index),
    .in_virtual_buttons(in_virtual_buttons),
    .out_read_byte     (out_read_byte),
    .out_target        (out_target),
    .out_target_address(out_target_address),
    .out_target_data   (out_target_data),
    .out_is_write      (out_is_write)
  );

endmodule

// ===== tb/console_bus_decode_ram_pads_unit_checker.sv =====
// Checker for the console bus decoder: watches the command and result ports,
// predicts each result from its own copy of the RAM, latches and shift registers.
// Depends on cbdrp_pkg for operation codes, target codes and decode addresses.
module console_bus_decode_ram_pads_unit_checker import cbdrp_pkg::*; #(
  parameter int RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic        in_pad_index,
  input  logic [11:0] in_virtual_buttons,
  input  logic        out_valid,
  input  logic [7:0]  out_read_byte,
  input  logic [2:0]  out_target,
  input  logic [15:0] out_target_address,
  input  logic [7:0]  out_target_data,
  input  logic        out_is_write,
  output int          mismatch_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [2:0]  target;
    logic [15:0] target_address;
    logic [7:0]  target_data;
    logic        is_write;
  } bus_result_t;

  logic [7:0]  ram_copy [RAM_DEPTH];
  logic [7:0]  pad_latch [2];
  logic [7:0]  pad_shift [2];
  logic        strobe_level;
  bus_result_t due_results [$];
  int          failures;

  function automatic logic [7:0] latch_from_host(input logic [11:0] v);
    logic [7:0] b;
    b[0] = v[0];
    b[1] = v[1];
    b[2] = v[7];
    b[3] = v[6];
    b[4] = v[8];
    b[5] = v[9];
    b[6] = v[10];
    b[7] = v[11];
    return b;
  endfunction

  function automatic logic [7:0] shift_out_pad(input logic p);
    logic lsb;
    if (strobe_level) begin
      pad_shift[p] = pad_latch[p];
      return {7'b0, pad_latch[p][0]} | PAD_OPEN_BUS;
    end
    lsb = pad_shift[p][0];
    pad_shift[p] = (pad_shift[p] >> 1) | PAD_REFILL;
    return {7'b0, lsb} | PAD_OPEN_BUS;
  endfunction

  function automatic bus_result_t decode_access(input logic [2:0] op, input logic [15:0] addr,
                                                input logic [7:0] data, input logic pad,
                                                input logic [11:0] vb);
    bus_result_t r;
    int idx;
    logic [15:0] paddr;
    r = '0;
    case (op)
      OP_CPU_RD, OP_CPU_WR: begin
        if (addr < ADDR_PPU_BASE) begin
          idx = int'(addr) % RAM_DEPTH;
          r.target = TGT_INTERNAL;
          r.target_address = 16'(idx);
          if (op == OP_CPU_WR) ram_copy[idx] = data;
          else r.read_byte = ram_copy[idx];
        end else if (addr < ADDR_APU_BASE) begin
          r.target = TGT_PPU_REGS;
          r.target_address = addr & PPU_REG_MASK;
        end else if (addr < ADDR_CART_BASE) begin
          if (op == OP_CPU_WR && addr == ADDR_DMA) begin
            r.target = TGT_DMA;
            r.target_address = {data, 8'h00};
          end else if (op == OP_CPU_WR && addr == ADDR_PAD0) begin
            r.target = TGT_INTERNAL;
            r.target_address = addr;
            strobe_level = data[0];
            if (strobe_level) begin
              pad_shift[0] = pad_latch[0];
              pad_shift[1] = pad_latch[1];
            end
          end else if (op == OP_CPU_RD && (addr == ADDR_PAD0 || addr == ADDR_PAD1)) begin
            r.target = TGT_INTERNAL;
            r.target_address = addr;
            r.read_byte = shift_out_pad(addr == ADDR_PAD1);
          end else begin
            r.target = TGT_APU;
            r.target_address = addr;
          end
        end else begin
          r.target = TGT_CART_PRG;
          r.target_address = addr;
        end
        if (op == OP_CPU_WR) begin
          r.is_write = 1'b1;
          r.target_data = data;
        end
      end
      OP_PPU_RD, OP_PPU_WR: begin
        paddr = addr & PPU_ADDR_MASK;
        r.target = (paddr < ADDR_PPU_BASE) ? TGT_CART_CHR : TGT_PPU_MEM;
        r.target_address = paddr;
        if (op == OP_PPU_WR) begin
          r.is_write = 1'b1;
          r.target_data = data;
        end
      end
      OP_BUTTONS: begin
        pad_latch[pad] = latch_from_host(vb);
        if (strobe_level) pad_shift[pad] = pad_latch[pad];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bus_result_t got;
    bus_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) ram_copy[i] = 8'h00;
      pad_latch[0] = 8'h00;
      pad_latch[1] = 8'h00;
      pad_shift[0] = 8'h00;
      pad_shift[1] = 8'h00;
      strobe_level = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        got = '{out_read_byte, out_target, out_target_address, out_target_data, out_is_write};
        if (due_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result rb=%h tg=%0d ta=%h td=%h wr=%b", $realtime,
                     got.read_byte, got.target, got.target_address, got.target_data,
                     got.is_write);
        end else begin
          want = due_results.pop_front();
          if (got.read_byte !== want.read_byte || got.target !== want.target ||
              got.target_address !== want.target_address ||
              got.target_data !== want.target_data || got.is_write !== want.is_write) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch expected rb=%h tg=%0d ta=%h td=%h wr=%b,",
                       $realtime, want.read_byte, want.target, want.target_address,
                       want.target_data, want.is_write,
                       " got rb=%h tg=%0d ta=%h td=%h wr=%b", got.read_byte, got.target,
                       got.target_address, got.target_data, got.is_write);
          end
        end
      end
      if (start && !busy)
        due_results.push_back(decode_access(in_operation, in_bus_address, in_write_byte,
                                            in_pad_index, in_virtual_buttons));
    end
    mismatch_count <= failures;
    results_due <= due_results.size();
  end

endmodule

// ===== tb/console_bus_decode_ram_pads_unit_tb.sv =====
// Top of the console bus decoder testbench: clock, reset, directed and random
// bus accesses and button updates, and the final verdict.
// Depends on cbdrp_pkg, the block itself and console_bus_decode_ram_pads_unit_checker.
module console_bus_decode_ram_pads_unit_tb import cbdrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1350;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [15:0] in_bus_address;
  logic [7:0]  in_write_byte;
  logic        in_pad_index;
  logic [11:0] in_virtual_buttons;
  logic        out_valid;
  logic [7:0]  out_read_byte;
  logic [2:0]  out_target;
  logic [15:0] out_target_address;
  logic [7:0]  out_target_data;
  logic        out_is_write;
  int          mismatch_count;
  int          results_due;
  int          accesses_sent;
  int          no_idle_left;

  console_bus_decode_ram_pads_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_bus_address(in_bus_address),
    .in_write_byte(in_write_byte), .in_pad_index(in_pad_index),
    .in_virtual_buttons(in_virtual_buttons), .out_valid(out_valid),
    .out_read_byte(out_read_byte), .out_target(out_target),
    .out_target_address(out_target_address), .out_target_data(out_target_data),
    .out_is_write(out_is_write)
  );

  console_bus_decode_ram_pads_unit_checker checker_inst (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_bus_address(in_bus_address),
    .in_write_byte(in_write_byte), .in_pad_index(in_pad_index),
    .in_virtual_buttons(in_virtual_buttons), .out_valid(out_valid),
    .out_read_byte(out_read_byte), .out_target(out_target),
    .out_target_address(out_target_address), .out_target_data(out_target_data),
    .out_is_write(out_is_write), .mismatch_count(mismatch_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("console_bus_decode_ram_pads_unit verification failed");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_idle_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue(input logic [2:0] op, input logic [15:0] addr, input logic [7:0] data,
                       input logic pad, input logic [11:0] vb);
    int gap;
    gap = idle_cycles();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_bus_address <= addr;
    in_write_byte <= data;
    in_pad_index <= pad;
    in_virtual_buttons <= vb;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op <= OP_BUTTONS) accesses_sent++;
  endtask

  function automatic logic [15:0] cpu_address();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 15) + 16'h0800 * $urandom_range(0, 3));
      2:    return 16'($urandom_range(0, 16'h1FFF));
      3:    return 16'($urandom_range(ADDR_PPU_BASE, ADDR_APU_BASE - 1));
      4:    return 16'($urandom_range(ADDR_APU_BASE, ADDR_CART_BASE - 1));
      5, 6: begin
        case ($urandom_range(0, 2))
          0:       return ADDR_DMA;
          1:       return ADDR_PAD0;
          default: return ADDR_PAD1;
        endcase
      end
      7:    return 16'($urandom_range(ADDR_CART_BASE, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pad_update(input logic pad);
    issue(OP_BUTTONS, 16'($urandom), 8'($urandom), pad, 12'($urandom));
  endtask

  task automatic pad_read();
    issue(OP_CPU_RD, $urandom_range(0, 1) ? ADDR_PAD1 : ADDR_PAD0, 8'($urandom), 1'($urandom),
          12'($urandom));
  endtask

  task automatic pad_sequence();
    int reads;
    pad_update(1'b0);
    pad_update(1'b1);
    issue(OP_CPU_WR, ADDR_PAD0, {7'($urandom), 1'b1}, 1'($urandom), 12'($urandom));
    if ($urandom_range(0, 3) == 0) pad_read();
    if ($urandom_range(0, 4) != 0)
      issue(OP_CPU_WR, ADDR_PAD0, {7'($urandom), 1'b0}, 1'($urandom), 12'($urandom));
    reads = $urandom_range(4, 12);
    repeat (reads) begin
      if ($urandom_range(0, 15) == 0) pad_update(1'($urandom));
      else pad_read();
    end
  endtask

  initial begin
    int pick;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_CPU_RD;
    in_bus_address <= 16'h0000;
    in_write_byte <= 8'h00;
    in_pad_index <= 1'b0;
    in_virtual_buttons <= 12'h000;
    accesses_sent = 0;
    no_idle_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(OP_CPU_WR, 16'h0000, 8'hFF, 1'b0, 12'h000);
    issue(OP_CPU_RD, 16'h1800, 8'h00, 1'b1, 12'hFFF);
    issue(OP_CPU_WR, 16'h07FF, 8'hA5, 1'b0, 12'h000);
    issue(OP_CPU_RD, 16'h1FFF, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_WR, 16'h3FFF, 8'h5A, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_PPU_BASE, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_APU_BASE, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_WR, ADDR_CART_BASE - 16'd1, 8'h33, 1'b0, 12'h000);
    issue(OP_CPU_WR, ADDR_DMA, 8'hFF, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_DMA, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_WR, ADDR_PAD1, 8'h01, 1'b0, 12'h000);
    issue(OP_BUTTONS, 16'h0000, 8'h00, 1'b0, 12'hFFF);
    issue(OP_BUTTONS, 16'hFFFF, 8'hFF, 1'b1, 12'h0C1);
    issue(OP_CPU_WR, ADDR_PAD0, 8'h01, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_PAD1, 8'h00, 1'b0, 12'h000);
    issue(OP_BUTTONS, 16'h0000, 8'h00, 1'b1, 12'h03E);
    issue(OP_CPU_WR, ADDR_PAD0, 8'hFE, 1'b0, 12'h000);
    repeat (9) issue(OP_CPU_RD, ADDR_PAD1, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_PAD0, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_RD, ADDR_CART_BASE, 8'h00, 1'b0, 12'h000);
    issue(OP_CPU_WR, 16'hFFFF, 8'h00, 1'b0, 12'h000);
    issue(OP_PPU_RD, 16'h1FFF, 8'h00, 1'b0, 12'h000);
    issue(OP_PPU_WR, 16'h3FFF, 8'hC3, 1'b0, 12'h000);
    issue(OP_PPU_RD, 16'hFFFF, 8'h00, 1'b0, 12'h000);
    issue(3'd5, 16'h0000, 8'hFF, 1'b1, 12'hFFF);
    issue(3'd7, 16'h4016, 8'h01, 1'b0, 12'hFFF);

    while (accesses_sent < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        issue(OP_CPU_RD, cpu_address(), 8'($urandom), 1'($urandom), 12'($urandom));
      else if (pick < 60)
        issue(OP_CPU_WR, cpu_address(), 8'($urandom), 1'($urandom), 12'($urandom));
      else if (pick < 70)
        issue(OP_PPU_RD, 16'($urandom), 8'($urandom), 1'($urandom), 12'($urandom));
      else if (pick < 80)
        issue(OP_PPU_WR, 16'($urandom), 8'($urandom), 1'($urandom), 12'($urandom));
      else if (pick < 86)
        pad_update(1'($urandom));
      else if (pick < 98)
        pad_sequence();
      else
        issue(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 1'($urandom),
              12'($urandom));
    end
    @(negedge clk);
    start <= 1'b0;

    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("console_bus_decode_ram_pads_unit verification clean");
    end else begin
      $display("console_bus_decode_ram_pads_unit verification failed");
    end
    $finish;
  end

endmodule
